/* rtl/core/sclru_pkg.sv */
// Shared types and constants for the split cache LRU age tracker.
`default_nettype none
package sclru_pkg;

  // Fixed field widths of a request
  localparam int unsigned SET_IDX_W   = 14;
  localparam int unsigned WAY_IDX_W   = 3;
  // Wide enough to hold any set count the tracker supports
  localparam int unsigned SET_EXT_W   = 17;

  // Age counter widths and most-recent ages
  localparam int unsigned DATA_AGE_W  = 3;
  localparam int unsigned INST_AGE_W  = 2;
  localparam logic [DATA_AGE_W-1:0] DATA_MAX_AGE = 3'h7;
  localparam logic [INST_AGE_W-1:0] INST_MAX_AGE = 2'h3;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Request classes decided by the front
  typedef enum logic [1:0] {
    OP_NOP,    // update that changes nothing
    OP_TOUCH,  // access or fill of a valid way
    OP_QUERY,  // victim query of a valid set
    OP_MISS    // victim query of a set out of range
  } sclru_op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } sclru_bk_state_e;

  // Classified request as it travels through the queue
  typedef struct packed {
    sclru_op_e              op;
    logic                   inst;
    logic [SET_IDX_W-1:0]   set;
    logic [WAY_IDX_W-1:0]   way;
    logic                   fill;
  } sclru_req_t;

endpackage
`default_nettype wire

/* rtl/core/sclru_front.sv */
// Front end: accepts requests, classifies them and pushes the useful ones.
`default_nettype none
module sclru_front #(
  parameter int unsigned SET_COUNT = 16384,
  parameter int unsigned DATA_WAYS = 8,
  parameter int unsigned INST_WAYS = 4
) (
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           action_i,
  input  wire logic                           cache_select_i,
  input  wire logic [sclru_pkg::SET_IDX_W-1:0] set_index_i,
  input  wire logic [sclru_pkg::WAY_IDX_W-1:0] way_index_i,
  input  wire logic                           fill_empty_i,
  input  wire logic                           clearing_i,
  input  wire logic                           queue_full_i,
  output logic                                push_o,
  output sclru_pkg::sclru_req_t               push_req_o
);
  import sclru_pkg::*;

  logic                 set_ok;
  logic                 way_ok;
  logic [SET_EXT_W-1:0] set_ext;
  sclru_op_e            op;

  // Check set and way against the configured geometry
  assign set_ext = {{(SET_EXT_W-SET_IDX_W){1'b0}}, set_index_i};
  assign set_ok  = set_ext < SET_EXT_W'(SET_COUNT);
  assign way_ok  = cache_select_i ? ({1'b0, way_index_i} < (WAY_IDX_W+1)'(INST_WAYS))
                                  : ({1'b0, way_index_i} < (WAY_IDX_W+1)'(DATA_WAYS));

  // Classify the request
  always_comb begin
    if (action_i) begin
      op = set_ok ? OP_QUERY : OP_MISS;
    end else begin
      op = (set_ok && way_ok) ? OP_TOUCH : OP_NOP;
    end
  end

  // Hold requests while the store is cleared or the queue is full
  assign in_stall_o = clearing_i || queue_full_i;

  // Push everything except updates that change nothing
  assign push_o          = in_valid_i && !in_stall_o && (op != OP_NOP);
  assign push_req_o.op   = op;
  assign push_req_o.inst = cache_select_i;
  assign push_req_o.set  = set_index_i;
  assign push_req_o.way  = way_index_i;
  assign push_req_o.fill = fill_empty_i;

endmodule
`default_nettype wire

/* rtl/core/sclru_queue.sv */
// Short request queue between the front and back ends.
`default_nettype none
module sclru_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sclru_pkg::sclru_req_t push_req_i,
  output logic                       full_o,
  output logic                       valid_o,
  output sclru_pkg::sclru_req_t      head_o,
  input  wire logic                  pop_i
);
  import sclru_pkg::*;

  sclru_req_t             entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sclru_back.sv */
// Back end: age stores, read-modify-write sequencer and result register.
`default_nettype none
module sclru_back #(
  parameter int unsigned SET_COUNT = 16384,
  parameter int unsigned DATA_WAYS = 8,
  parameter int unsigned INST_WAYS = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire sclru_pkg::sclru_req_t           q_head_i,
  output logic                                 q_pop_o,
  output logic                                 clearing_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [sclru_pkg::WAY_IDX_W-1:0]      victim_way_o,
  output logic                                 victim_found_o
);
  import sclru_pkg::*;

  localparam int unsigned SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned DW_IDX   = $clog2(DATA_WAYS);
  localparam int unsigned IW_IDX   = $clog2(INST_WAYS);
  localparam int unsigned DATA_ROW = DATA_WAYS * DATA_AGE_W;
  localparam int unsigned INST_ROW = INST_WAYS * INST_AGE_W;

  // Age stores
  logic [DATA_ROW-1:0] data_mem [SET_COUNT];
  logic [INST_ROW-1:0] inst_mem [SET_COUNT];
  logic [DATA_ROW-1:0] data_rd_q;
  logic [INST_ROW-1:0] inst_rd_q;

  sclru_bk_state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;
  sclru_req_t       cur_q;

  logic [SET_EXT_W-1:0] head_ext, cur_ext;
  logic [SET_W-1:0]     rd_addr, wr_addr;
  logic                 data_we, inst_we;
  logic [DATA_ROW-1:0]  data_wr_row, data_new_row;
  logic [INST_ROW-1:0]  inst_wr_row, inst_new_row;

  logic [DATA_AGE_W-1:0] d_age [DATA_WAYS];
  logic [INST_AGE_W-1:0] i_age [INST_WAYS];
  logic [DATA_AGE_W-1:0] d_ref;
  logic [INST_AGE_W-1:0] i_ref;

  logic                 d_found, i_found, res_found;
  logic [WAY_IDX_W-1:0] d_way, i_way, res_way;
  logic                 out_free, load_out;

  logic                 out_valid_q, out_valid_d;
  logic [WAY_IDX_W-1:0] victim_way_q;
  logic                 victim_found_q;

  assign head_ext = {{(SET_EXT_W-SET_IDX_W){1'b0}}, q_head_i.set};
  assign cur_ext  = {{(SET_EXT_W-SET_IDX_W){1'b0}}, cur_q.set};
  assign rd_addr  = head_ext[SET_W-1:0];

  // Split the read rows into ages
  for (genvar g = 0; g < DATA_WAYS; g++) begin : g_data_age
    assign d_age[g] = data_rd_q[g*DATA_AGE_W +: DATA_AGE_W];
  end
  for (genvar g = 0; g < INST_WAYS; g++) begin : g_inst_age
    assign i_age[g] = inst_rd_q[g*INST_AGE_W +: INST_AGE_W];
  end

  assign d_ref = d_age[cur_q.way[DW_IDX-1:0]];
  assign i_ref = i_age[cur_q.way[IW_IDX-1:0]];

  // Make the touched way most recent and age the ways at least as recent, or on a fill the lower ways
  for (genvar g = 0; g < DATA_WAYS; g++) begin : g_data_upd
    logic age_it;
    assign age_it = cur_q.fill ? (WAY_IDX_W'(g) < cur_q.way) : (d_age[g] >= d_ref);
    assign data_new_row[g*DATA_AGE_W +: DATA_AGE_W] =
        (WAY_IDX_W'(g) == cur_q.way) ? DATA_MAX_AGE :
        (age_it && (d_age[g] != '0)) ? d_age[g] - 1'b1 : d_age[g];
  end
  for (genvar g = 0; g < INST_WAYS; g++) begin : g_inst_upd
    logic age_it;
    assign age_it = cur_q.fill ? (WAY_IDX_W'(g) < cur_q.way) : (i_age[g] >= i_ref);
    assign inst_new_row[g*INST_AGE_W +: INST_AGE_W] =
        (WAY_IDX_W'(g) == cur_q.way) ? INST_MAX_AGE :
        (age_it && (i_age[g] != '0)) ? i_age[g] - 1'b1 : i_age[g];
  end

  // Find the lowest way of age zero and pick the result for the request
  always_comb begin
    d_found = 1'b0;
    d_way   = '0;
    for (int i = DATA_WAYS - 1; i >= 0; i--) begin
      if (d_age[i] == '0) begin
        d_found = 1'b1;
        d_way   = WAY_IDX_W'(i);
      end
    end
    i_found = 1'b0;
    i_way   = '0;
    for (int i = INST_WAYS - 1; i >= 0; i--) begin
      if (i_age[i] == '0) begin
        i_found = 1'b1;
        i_way   = WAY_IDX_W'(i);
      end
    end
    if (cur_q.op == OP_MISS) begin
      res_found = 1'b0;
      res_way   = '0;
    end else if (cur_q.inst) begin
      res_found = i_found;
      res_way   = i_way;
    end else begin
      res_found = d_found;
      res_way   = d_way;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence clear pass, read and write back
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    q_pop_o     = 1'b0;
    load_out    = 1'b0;
    data_we     = 1'b0;
    inst_we     = 1'b0;
    wr_addr     = cur_ext[SET_W-1:0];
    data_wr_row = data_new_row;
    inst_wr_row = inst_new_row;
    clearing_o  = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        clearing_o  = 1'b1;
        data_we     = 1'b1;
        inst_we     = 1'b1;
        wr_addr     = clr_cnt_q;
        data_wr_row = '0;
        inst_wr_row = '0;
        clr_cnt_d   = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(SET_COUNT - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cur_q.op == OP_TOUCH) begin
          data_we = !cur_q.inst;
          inst_we = cur_q.inst;
          state_d = BK_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Latch the popped request
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
  end

  // Data age store
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[wr_addr] <= data_wr_row;
    end
    if (q_pop_o) begin
      data_rd_q <= data_mem[rd_addr];
    end
  end

  // Instruction age store
  always_ff @(posedge clk_i) begin
    if (inst_we) begin
      inst_mem[wr_addr] <= inst_wr_row;
    end
    if (q_pop_o) begin
      inst_rd_q <= inst_mem[rd_addr];
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      victim_way_q   <= res_way;
      victim_found_q <= res_found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_way_o   = victim_way_q;
  assign victim_found_o = victim_found_q;

endmodule
`default_nettype wire

/* rtl/core/split_cache_lru_tracker_core.sv */
// Top level of the split cache LRU age tracker.
//
// Usage: requests enter on the in channel (in_valid_i / in_stall_o) and carry
// action_i, cache_select_i, set_index_i, way_index_i and fill_empty_i. An
// update request (action 0) records an access or fill and gives no result; a
// query request (action 1) gives one result on the out channel
// (out_valid_o / out_stall_i) with victim_way_o and victim_found_o.
// The front accepts one request per cycle, while in_stall_o is low, into a
// two-entry queue; the back performs a read-modify-write of one set per
// request (memory read, then update and write back) and pops no further
// request until the current one is written back or its result is loaded.
// Updates that name a way or set out of range are accepted and dropped at
// once. A query result passes the queue, request and output registers.
// After reset the back clears both age stores, one set per cycle, from set 0
// up to SET_COUNT-1; in_stall_o stays high during that pass.
// When the receiver stalls, the result waits in the output register, the
// back waits on the next query, and the queue fills before in_stall_o rises.
`default_nettype none
module split_cache_lru_tracker_core #(
  parameter int unsigned SET_COUNT = 16384,
  parameter int unsigned DATA_WAYS = 8,
  parameter int unsigned INST_WAYS = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             action_i,
  input  wire logic                             cache_select_i,
  input  wire logic [sclru_pkg::SET_IDX_W-1:0]  set_index_i,
  input  wire logic [sclru_pkg::WAY_IDX_W-1:0]  way_index_i,
  input  wire logic                             fill_empty_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [sclru_pkg::WAY_IDX_W-1:0]       victim_way_o,
  output logic                                  victim_found_o
);
  import sclru_pkg::*;

  logic       clearing;
  logic       queue_full;
  logic       push;
  sclru_req_t push_req;
  logic       q_valid;
  sclru_req_t q_head;
  logic       q_pop;

  sclru_front #(
    .SET_COUNT (SET_COUNT),
    .DATA_WAYS (DATA_WAYS),
    .INST_WAYS (INST_WAYS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .cache_select_i (cache_select_i),
    .set_index_i    (set_index_i),
    .way_index_i    (way_index_i),
    .fill_empty_i   (fill_empty_i),
    .clearing_i     (clearing),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .push_req_o     (push_req)
  );

  sclru_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (queue_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  sclru_back #(
    .SET_COUNT (SET_COUNT),
    .DATA_WAYS (DATA_WAYS),
    .INST_WAYS (INST_WAYS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .victim_way_o   (victim_way_o),
    .victim_found_o (victim_found_o)
  );

endmodule
`default_nettype wire
